// ===== sv/blf_pkg.sv =====
// Shared types and constants for the line-drawing framebuffer engine.
package blf_pkg;

  // Default framebuffer geometry: columns per page and number of 8-row pages.
  localparam int FB_WIDTH_DEF = 96;
  localparam int FB_PAGES_DEF = 4;

  // Bit mask of the top pixel in a byte column; row y sits at TOP_BIT >> (y % 8).
  localparam logic [7:0] TOP_BIT = 8'h80;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_DRAW = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_FILL = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_LINE,
    ST_LINE_WR,
    ST_READ,
    ST_READ_WAIT,
    ST_FILL,
    ST_DONE
  } blf_state_t;

endpackage

// ===== sv/bresenham_line_framebuffer.sv =====
// Line-drawing engine with its own page-organized monochrome framebuffer.
//
// The engine owns a framebuffer of FB_PAGES pages of FB_WIDTH bytes. Each byte
// is a column of 8 pixels with the top pixel in the MSB, so pixel (x, y) lives
// in byte (y / 8) * FB_WIDTH + x. Pixels whose byte index falls at or past the
// end of the buffer are skipped when drawn and read back as 0; a column past
// FB_WIDTH therefore wraps into the next page when that page exists.
// An item with mode 0 draws a line from the start to the end point with
// integer Bresenham in the current draw_color: horizontal and vertical lines
// include both end points, other lines stop one pixel short of the end point,
// and a line whose start equals its end sets that one pixel. Mode 1 returns
// the pixel at the start point. Mode 2 writes draw_color (0x00 or 0x01) into
// every byte. Mode 3 does nothing. Every item returns exactly one result with
// done_res set and pixel_value holding the read pixel (0 for other modes).
// The block works on one item at a time and is not ready while it is busy.
// In a draw, every pixel is a read-modify-write through the single port
// pair of the framebuffer memory, a read in the line state and a write in
// the write state (a pixel that lies outside the buffer gets neither), and
// the Bresenham decision term is updated by one shared adder once per pixel.
// A fill writes one byte per cycle. After reset the engine clears the
// buffer in a pass over every byte, during which in_ready stays low;
// draw_color may be written at any time the block is idle, including
// during that pass. Results sit in an output register, so a new item is
// taken while an earlier result still waits for out_ready.
module bresenham_line_framebuffer
  import blf_pkg::*;
#(
  parameter int FB_WIDTH = FB_WIDTH_DEF,
  parameter int FB_PAGES = FB_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration write port for draw_color.
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // Input item channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [6:0] x_start,
  input  logic [5:0] y_start,
  input  logic [6:0] x_end,
  input  logic [5:0] y_end,
  // Result item channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       pixel_value,
  output logic       done_res
);

  // Buffer size in bytes and the width of a memory index.
  localparam int FB_BYTES = FB_WIDTH * FB_PAGES;
  localparam int AW       = $clog2(FB_BYTES);
  // Width of a raw byte position, large enough for any page and column.
  localparam int POS_W    = $clog2(7 * FB_WIDTH + 128);
  localparam logic [POS_W-1:0] WIDTH_C = POS_W'(FB_WIDTH);
  localparam logic [POS_W-1:0] BYTES_C = POS_W'(FB_BYTES);
  localparam logic [AW-1:0]    LAST_C  = AW'(FB_BYTES - 1);

  // Framebuffer memory.
  logic [7:0]    mem [FB_BYTES];
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rd_data;

  // Sequencer and walker registers.
  blf_state_t    st, st_next;
  logic          draw_color;
  logic [1:0]    op, op_next;
  logic [6:0]    cur_x, cur_x_next;
  logic [5:0]    cur_y, cur_y_next;
  logic [6:0]    end_x, end_x_next;
  logic [5:0]    end_y, end_y_next;
  logic [8:0]    error_term, error_term_next;
  logic [6:0]    steps_left, steps_left_next;
  logic          steep, steep_next;
  logic          x_neg, x_neg_next;
  logic          y_neg, y_neg_next;
  logic          axis, axis_next;
  logic          last_pix, last_pix_next;
  logic [8:0]    d_ge, d_ge_next;
  logic [7:0]    d_lt, d_lt_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          pix, pix_next;
  logic          out_valid_next;
  logic          pixel_value_next;

  // Line setup arithmetic, used in the setup state only.
  logic [7:0] dx;
  logic [6:0] dy;
  logic [6:0] adx;
  logic [5:0] ady;
  logic [6:0] len;
  logic [6:0] minor;
  logic [9:0] err_init;

  assign dx    = {1'b0, end_x} - {1'b0, cur_x};
  assign dy    = {1'b0, end_y} - {1'b0, cur_y};
  assign adx   = dx[7] ? 7'(~dx + 8'd1) : dx[6:0];
  assign ady   = dy[6] ? 6'(~dy + 7'd1) : dy[5:0];
  assign len   = ({1'b0, ady} > adx) ? {1'b0, ady} : adx;
  assign minor = ({1'b0, ady} > adx) ? adx : {1'b0, ady};
  assign err_init = {2'b00, minor, 1'b0} - {3'b000, len};

  // Pixel position of the walker and its bit within the byte column.
  logic [POS_W-1:0] pos;
  logic             pix_in_range;
  logic [AW-1:0]    pix_idx;
  logic [7:0]       pix_mask;

  assign pos          = POS_W'(cur_y[5:3]) * WIDTH_C + POS_W'(cur_x);
  assign pix_in_range = pos < BYTES_C;
  assign pix_idx      = pos[AW-1:0];
  assign pix_mask     = TOP_BIT >> cur_y[2:0];

  // One Bresenham step: the shared decision-term adder and the coordinate moves.
  logic       err_nonneg;
  logic       x_move;
  logic       y_move;
  logic [9:0] err_sum;
  logic [6:0] x_step;
  logic [5:0] y_step;

  assign err_nonneg = !error_term[8];
  assign x_move     = steep ? err_nonneg : 1'b1;
  assign y_move     = steep ? 1'b1 : err_nonneg;
  assign err_sum    = {error_term[8], error_term}
                    + (err_nonneg ? {d_ge[8], d_ge} : {2'b00, d_lt});
  assign x_step     = !x_move ? cur_x : (x_neg ? cur_x - 7'd1 : cur_x + 7'd1);
  assign y_step     = !y_move ? cur_y : (y_neg ? cur_y - 6'd1 : cur_y + 6'd1);

  assign in_ready = (st == ST_IDLE);
  assign done_res = 1'b1;

  // Next state, datapath updates and memory controls.
  always_comb begin
    st_next          = st;
    op_next          = op;
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    end_x_next       = end_x;
    end_y_next       = end_y;
    error_term_next  = error_term;
    steps_left_next  = steps_left;
    steep_next       = steep;
    x_neg_next       = x_neg;
    y_neg_next       = y_neg;
    axis_next        = axis;
    last_pix_next    = last_pix;
    d_ge_next        = d_ge;
    d_lt_next        = d_lt;
    cnt_next         = cnt;
    pix_next         = pix;
    out_valid_next   = out_valid && !out_ready;
    pixel_value_next = pixel_value;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = pix_idx;
    mem_wdata        = draw_color ? (rd_data | pix_mask) : (rd_data & ~pix_mask);

    unique case (st)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = 8'h00;
        cnt_next  = cnt + AW'(1);
        if (cnt == LAST_C) begin
          st_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_next    = mode;
          cur_x_next = x_start;
          cur_y_next = y_start;
          end_x_next = x_end;
          end_y_next = y_end;
          pix_next   = 1'b0;
          cnt_next   = '0;
          unique case (mode)
            MODE_DRAW: st_next = ST_SETUP;
            MODE_READ: st_next = ST_READ;
            MODE_FILL: st_next = ST_FILL;
            default:   st_next = ST_DONE;
          endcase
        end
      end

      ST_SETUP: begin
        steep_next      = {1'b0, ady} > adx;
        x_neg_next      = dx[7];
        y_neg_next      = dy[6];
        axis_next       = (dx == 8'd0) || (dy == 7'd0);
        last_pix_next   = 1'b0;
        steps_left_next = len;
        error_term_next = err_init[8:0];
        d_lt_next       = {minor, 1'b0};
        d_ge_next       = {1'b0, minor, 1'b0} - {1'b0, len, 1'b0};
        st_next         = ST_LINE;
      end

      ST_LINE: begin
        if (steps_left == 7'd0) begin
          // Axis-aligned lines and single points also take the end pixel,
          // drawn as one more pass with the walker placed on the end point.
          if (axis && !last_pix) begin
            cur_x_next      = end_x;
            cur_y_next      = end_y;
            steps_left_next = 7'd1;
            last_pix_next   = 1'b1;
          end else begin
            st_next = ST_DONE;
          end
        end else if (pix_in_range) begin
          mem_re  = 1'b1;
          st_next = ST_LINE_WR;
        end else begin
          cur_x_next      = x_step;
          cur_y_next      = y_step;
          error_term_next = err_sum[8:0];
          steps_left_next = steps_left - 7'd1;
        end
      end

      ST_LINE_WR: begin
        mem_we          = 1'b1;
        cur_x_next      = x_step;
        cur_y_next      = y_step;
        error_term_next = err_sum[8:0];
        steps_left_next = steps_left - 7'd1;
        st_next         = ST_LINE;
      end

      ST_READ: begin
        if (pix_in_range) begin
          mem_re  = 1'b1;
          st_next = ST_READ_WAIT;
        end else begin
          st_next = ST_DONE;
        end
      end

      ST_READ_WAIT: begin
        pix_next = |(rd_data & pix_mask);
        st_next  = ST_DONE;
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = {7'b0000000, draw_color};
        cnt_next  = cnt + AW'(1);
        if (cnt == LAST_C) begin
          st_next = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          pixel_value_next = (op == MODE_READ) ? pix : 1'b0;
          st_next          = ST_IDLE;
        end
      end

      default: st_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  // Control and walker registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= 1'b0;
      cnt        <= '0;
      out_valid  <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      error_term <= '0;
      steps_left <= '0;
      last_pix   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        draw_color <= cfg_wr_data;
      end
      cnt        <= cnt_next;
      out_valid  <= out_valid_next;
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_term_next;
      steps_left <= steps_left_next;
      last_pix   <= last_pix_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op          <= op_next;
    end_x       <= end_x_next;
    end_y       <= end_y_next;
    steep       <= steep_next;
    x_neg       <= x_neg_next;
    y_neg       <= y_neg_next;
    axis        <= axis_next;
    d_ge        <= d_ge_next;
    d_lt        <= d_lt_next;
    pix         <= pix_next;
    pixel_value <= pixel_value_next;
  end

  // Framebuffer memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[pix_idx];
    end
  end

endmodule
